// ===== sv/fct_pkg.sv =====
// Shared types, widths and helpers for the frustum cull test block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fct_pkg;

    // Fixed field geometry
    localparam int COORD_WIDTH    = 16;
    localparam int NUM_PLANES_DEF = 6;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int NRM_W          = 14;   // plane normal entry, Q1.12
    localparam int DOFS_W         = 22;   // plane offset, Q16.5
    localparam int COMP_W         = COORD_WIDTH + 1;
    localparam int CORNER_W       = 2 * COORD_WIDTH + 4;
    localparam int DIST_W         = 64;
    localparam int PLANE_IDX_W    = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [CORNER_W-1:0]    corner_t;
    typedef logic signed [COMP_W-1:0]      comp_t;

    typedef enum logic [1:0] {
        REQ_POINT  = 2'd0,
        REQ_SPHERE = 2'd1,
        REQ_BOX    = 2'd2,
        REQ_RSVD   = 2'd3
    } req_t;

    // One item travelling down the cell chain
    typedef struct packed {
        logic                    valid;
        req_t                    req;
        coord_t [2:0]            pos;
        coord_t                  rad;
        corner_t [7:0][2:0]      corner;
        logic                    vis;
    } beat_t;

    // Plane cache write from the derivation unit
    typedef struct packed {
        logic                   en;
        logic [PLANE_IDX_W-1:0] idx;
        logic [63:0]            data;
    } plane_wr_t;

    typedef enum logic [2:0] {
        PG_IDLE,
        PG_LOAD,
        PG_SQUARE,
        PG_ROOT,
        PG_DIVIDE,
        PG_STORE
    } pg_state_t;

    // Signed entry i of a packed word
    function automatic coord_t elem(input logic [63:0] v, input int unsigned i);
        elem = coord_t'(v[i*COORD_WIDTH +: COORD_WIDTH]);
    endfunction

endpackage

`default_nettype wire

// ===== sv/frustum_cull_test_top.sv =====
// Beats are registered in fct_xform and each cell; one a cycle while busy is low.
// Each plane is tested by its own cell in the chain; done cannot be stalled.
// Reset loads the identity matrix and derives the planes, busy high meanwhile,
// one plane at a time (root and divide skipped for a zero-length normal). A register write
// re-derives all planes the same way; bit-serial root and divider, one shared unit.
// Depends on fct_pkg, fct_xform, fct_cell, fct_plane_gen.
`default_nettype none

module frustum_cull_test_top #(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = fct_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [47:0]        pos_a,
    input  wire logic [47:0]        pos_b,
    input  wire logic signed [15:0] sphere_radius,
    input  wire logic [63:0]        xform_row0,
    input  wire logic [63:0]        xform_row1,
    input  wire logic [63:0]        xform_row2,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    output logic                    done,
    output logic                    visible
);

    logic [63:0]         col_reg [4];
    logic [63:0]         plane_reg [NUM_PLANES];
    fct_pkg::plane_wr_t  pwr;
    fct_pkg::beat_t      chain [NUM_PLANES+1];

    // Matrix columns, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg[0] <= 64'h0000_0000_0000_0100;
            col_reg[1] <= 64'h0000_0000_0100_0000;
            col_reg[2] <= 64'h0000_0100_0000_0000;
            col_reg[3] <= 64'h0100_0000_0000_0000;
        end
        else if (cfg_we)
        begin
            col_reg[cfg_index] <= cfg_data;
        end
    end

    fct_plane_gen #(
        .NUM_PLANES (NUM_PLANES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_plane_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .kick  (cfg_we),
        .col0  (col_reg[0]),
        .col1  (col_reg[1]),
        .col2  (col_reg[2]),
        .col3  (col_reg[3]),
        .busy  (busy),
        .wr    (pwr)
    );

    // Plane cache
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            if (pwr.en && pwr.idx == fct_pkg::PLANE_IDX_W'(i))
            begin
                plane_reg[i] <= pwr.data;
            end
        end
    end

    fct_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (start & ~busy),
        .req_type      (req_type),
        .pos_a         (pos_a),
        .pos_b         (pos_b),
        .sphere_radius (sphere_radius),
        .xform_row0    (xform_row0),
        .xform_row1    (xform_row1),
        .xform_row2    (xform_row2),
        .beat_out      (chain[0])
    );

    // Chain of plane cells
    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_cell
        fct_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .plane    (plane_reg[g]),
            .beat_in  (chain[g]),
            .beat_out (chain[g+1])
        );
    end

    assign done    = chain[NUM_PLANES].valid;
    assign visible = chain[NUM_PLANES].vis;

endmodule

`default_nettype wire

// ===== sv/fct_xform.sv =====
// Front stage: registers the request, builds the eight transformed box corners.
// Depends on fct_pkg.
`default_nettype none

module fct_xform #(
    parameter int FRAC_BITS = fct_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        req_type,
    input  wire logic [47:0]       pos_a,
    input  wire logic [47:0]       pos_b,
    input  wire logic signed [15:0] sphere_radius,
    input  wire logic [63:0]       xform_row0,
    input  wire logic [63:0]       xform_row1,
    input  wire logic [63:0]       xform_row2,
    output fct_pkg::beat_t         beat_out
);

    localparam int PW = 2 * fct_pkg::COORD_WIDTH;

    logic                      s1_valid_reg;
    fct_pkg::req_t             s1_req_reg;
    fct_pkg::coord_t [2:0]     s1_pos_reg;
    fct_pkg::coord_t           s1_rad_reg;
    logic signed [PW-1:0]      s1_pa_reg [3][3];
    logic signed [PW-1:0]      s1_pb_reg [3][3];
    fct_pkg::corner_t          s1_tr_reg [3];
    logic signed [PW-1:0]      pa_next [3][3];
    logic signed [PW-1:0]      pb_next [3][3];
    fct_pkg::corner_t          tr_next [3];
    fct_pkg::coord_t [2:0]     pos_next;
    fct_pkg::beat_t            beat_reg;
    fct_pkg::beat_t            beat_next;
    logic [63:0]               rows [3];

    assign rows[0] = xform_row0;
    assign rows[1] = xform_row1;
    assign rows[2] = xform_row2;

    // Row-by-coordinate products for both box extremes
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pa_next[r][c] = fct_pkg::elem(rows[r], c) * fct_pkg::elem(64'(pos_a), c);
                pb_next[r][c] = fct_pkg::elem(rows[r], c) * fct_pkg::elem(64'(pos_b), c);
            end
            tr_next[r] = fct_pkg::corner_t'(fct_pkg::elem(rows[r], 3)) <<< FRAC_BITS;
        end
        for (int c = 0; c < 3; c++)
        begin
            pos_next[c] = fct_pkg::elem(64'(pos_a), c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg <= fct_pkg::req_t'(req_type);
        s1_pos_reg <= pos_next;
        s1_rad_reg <= sphere_radius;
        s1_pa_reg  <= pa_next;
        s1_pb_reg  <= pb_next;
        s1_tr_reg  <= tr_next;
    end

    // Corner k picks max on axis c when bit c of k is set
    always_comb
    begin
        beat_next.valid = s1_valid_reg;
        beat_next.req   = s1_req_reg;
        beat_next.pos   = s1_pos_reg;
        beat_next.rad   = s1_rad_reg;
        beat_next.vis   = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                beat_next.corner[k][r] = s1_tr_reg[r];
                for (int c = 0; c < 3; c++)
                begin
                    beat_next.corner[k][r] = beat_next.corner[k][r]
                        + fct_pkg::corner_t'(k[c] ? s1_pb_reg[r][c] : s1_pa_reg[r][c]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire

// ===== sv/fct_cell.sv =====
// One cell of the culling chain: tests the passing beat against one plane.
// Depends on fct_pkg.
`default_nettype none

module fct_cell #(
    parameter int FRAC_BITS = fct_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [63:0] plane,
    input  fct_pkg::beat_t   beat_in,
    output fct_pkg::beat_t   beat_out
);

    localparam int PSH = 7 + FRAC_BITS;
    localparam int BSH = 7 + 2 * FRAC_BITS;

    logic signed [fct_pkg::NRM_W-1:0]  nrm [3];
    logic signed [fct_pkg::DIST_W-1:0] dofs;
    logic signed [fct_pkg::DIST_W-1:0] rad_x;
    logic signed [fct_pkg::DIST_W-1:0] dist_p;
    logic signed [fct_pkg::DIST_W-1:0] lim;
    logic signed [fct_pkg::DIST_W-1:0] dist_c [8];
    logic [7:0]                        behind;
    logic                              cull;
    fct_pkg::beat_t                    beat_reg;
    fct_pkg::beat_t                    beat_next;

    assign nrm[0] = plane[13:0];
    assign nrm[1] = plane[27:14];
    assign nrm[2] = plane[41:28];
    assign dofs   = fct_pkg::DIST_W'(signed'(plane[63:42]));
    assign rad_x  = fct_pkg::DIST_W'(beat_in.rad);

    // Signed distances of the point and of the eight corners
    always_comb
    begin
        dist_p = nrm[0] * beat_in.pos[0] + nrm[1] * beat_in.pos[1]
               + nrm[2] * beat_in.pos[2] + (dofs <<< PSH);
        lim = (beat_in.req == fct_pkg::REQ_SPHERE) ? -(rad_x <<< 12) : '0;
        for (int k = 0; k < 8; k++)
        begin
            dist_c[k] = nrm[0] * beat_in.corner[k][0] + nrm[1] * beat_in.corner[k][1]
                      + nrm[2] * beat_in.corner[k][2] + (dofs <<< BSH);
            behind[k] = dist_c[k] < 0;
        end
    end

    always_comb
    begin
        case (beat_in.req)
            fct_pkg::REQ_POINT,
            fct_pkg::REQ_SPHERE: cull = dist_p < lim;
            fct_pkg::REQ_BOX:    cull = &behind;
            default:             cull = 1'b0;
        endcase
        beat_next     = beat_in;
        beat_next.vis = beat_in.vis & ~cull;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire

// ===== sv/fct_plane_gen.sv =====
// Plane derivation sequencer: extracts, normalizes and writes the clip planes.
// Bit-serial square root and restoring divider. Depends on fct_pkg.
`default_nettype none

module fct_plane_gen #(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = fct_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        kick,
    input  wire logic [63:0] col0,
    input  wire logic [63:0] col1,
    input  wire logic [63:0] col2,
    input  wire logic [63:0] col3,
    output logic             busy,
    output fct_pkg::plane_wr_t wr
);

    localparam int PW     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int SUM_W  = 34;
    localparam int RAD_W  = SUM_W + 16;
    localparam int LEN_W  = RAD_W / 2;
    localparam int REM_W  = LEN_W + 2;
    localparam int NUM_W  = 38;
    localparam int CNT_W  = 6;
    localparam int RSH    = (FRAC_BITS >= 5) ? FRAC_BITS - 5 : 0;
    localparam int LSH    = (FRAC_BITS < 5) ? 5 - FRAC_BITS : 0;
    localparam int NW     = fct_pkg::NRM_W;
    localparam int DW     = fct_pkg::DOFS_W;

    fct_pkg::pg_state_t state_reg, state_next;
    logic [PW-1:0]      p_reg, p_next;
    fct_pkg::comp_t     comp_reg [4];
    fct_pkg::comp_t     comp_next [4];
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [LEN_W-1:0]   root_reg, root_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [1:0]         dsel_reg, dsel_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [LEN_W-1:0]   drem_reg, drem_next;
    logic [NW-1:0]      n_reg [3];
    logic [NW-1:0]      n_next [3];
    logic [DW-1:0]      d_reg, d_next;

    logic [63:0]                 cols [4];
    int unsigned                 row_sel;
    fct_pkg::coord_t             top_e, oth_e;
    logic signed [2*fct_pkg::COMP_W-1:0] sq;
    logic [REM_W+1:0]            rem_t;
    logic [REM_W-1:0]            trial;
    logic [LEN_W:0]              dt;
    logic                        dge;
    fct_pkg::comp_t              csel;
    logic [NUM_W-1:0]            q;
    logic signed [DW+1:0]        dz;

    assign cols[0] = col0;
    assign cols[1] = col1;
    assign cols[2] = col2;
    assign cols[3] = col3;

    // Rounded dividend: |c| scaled, plus half the divisor
    function automatic logic [NUM_W-1:0] div_num(input fct_pkg::comp_t c, input logic is_d,
                                                 input logic [LEN_W-1:0] l);
        logic [fct_pkg::COMP_W-1:0] m;
        m = c[fct_pkg::COMP_W-1] ? fct_pkg::COMP_W'(-c) : fct_pkg::COMP_W'(c);
        div_num = (NUM_W'(m) << (is_d ? 13 : 20)) + NUM_W'(l >> 1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fct_pkg::PG_LOAD;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        comp_reg <= comp_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        dsel_reg <= dsel_next;
        quo_reg  <= quo_next;
        drem_reg <= drem_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
    end

    // Next state and datapath
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        comp_next  = comp_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        dsel_next  = dsel_reg;
        quo_next   = quo_reg;
        drem_next  = drem_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        wr.en      = 1'b0;
        wr.idx     = fct_pkg::PLANE_IDX_W'(p_reg);
        wr.data    = {d_reg, n_reg[2], n_reg[1], n_reg[0]};

        row_sel = 32'(p_reg) >> 1;
        sq      = comp_reg[cnt_reg[1:0]] * comp_reg[cnt_reg[1:0]];
        rem_t   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {root_reg, 2'b01};
        dt      = {drem_reg, quo_reg[NUM_W-1]};
        dge     = dt >= {1'b0, root_reg};
        csel    = comp_reg[dsel_reg];
        q       = {quo_reg[NUM_W-2:0], dge};
        dz      = ((DW+2)'(comp_reg[3]) >>> RSH) <<< LSH;
        top_e   = '0;
        oth_e   = '0;

        case (state_reg)
            fct_pkg::PG_IDLE:
            begin
            end
            // Row 3 plus or minus the selected row
            fct_pkg::PG_LOAD:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    top_e = fct_pkg::elem(cols[c], 3);
                    oth_e = fct_pkg::elem(cols[c], row_sel);
                    comp_next[c] = p_reg[0]
                        ? fct_pkg::comp_t'(top_e) - fct_pkg::comp_t'(oth_e)
                        : fct_pkg::comp_t'(top_e) + fct_pkg::comp_t'(oth_e);
                end
                sum_next   = '0;
                cnt_next   = '0;
                state_next = fct_pkg::PG_SQUARE;
            end
            // One square per cycle
            fct_pkg::PG_SQUARE:
            begin
                sum_next = sum_reg + SUM_W'(unsigned'(sq));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(2))
                begin
                    cnt_next = '0;
                    if (sum_next == '0)
                    begin
                        // Zero-length normal: keep plane, offset to Q16.5
                        n_next[0]  = '0;
                        n_next[1]  = '0;
                        n_next[2]  = '0;
                        d_next     = DW'(dz);
                        state_next = fct_pkg::PG_STORE;
                    end
                    else
                    begin
                        rad_next   = RAD_W'(sum_next) << 16;
                        root_next  = '0;
                        rem_next   = '0;
                        state_next = fct_pkg::PG_ROOT;
                    end
                end
            end
            // Integer square root, one result bit a cycle
            fct_pkg::PG_ROOT:
            begin
                if (rem_t >= (REM_W+2)'(trial))
                begin
                    rem_next  = REM_W'(rem_t - (REM_W+2)'(trial));
                    root_next = {root_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(rem_t);
                    root_next = {root_reg[LEN_W-2:0], 1'b0};
                end
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LEN_W - 1))
                begin
                    cnt_next   = '0;
                    dsel_next  = '0;
                    drem_next  = '0;
                    quo_next   = div_num(comp_reg[0], 1'b0, root_next);
                    state_next = fct_pkg::PG_DIVIDE;
                end
            end
            // Restoring division, one quotient bit a cycle
            fct_pkg::PG_DIVIDE:
            begin
                drem_next = dge ? LEN_W'(dt - {1'b0, root_reg}) : LEN_W'(dt);
                quo_next  = q;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    cnt_next = '0;
                    if (dsel_reg == 2'd3)
                    begin
                        if (csel[fct_pkg::COMP_W-1])
                            d_next = (q > NUM_W'(1 << (DW-1))) ? DW'(1 << (DW-1)) : DW'(-q);
                        else
                            d_next = (q > NUM_W'((1 << (DW-1)) - 1))
                                   ? DW'((1 << (DW-1)) - 1) : DW'(q);
                        state_next = fct_pkg::PG_STORE;
                    end
                    else
                    begin
                        if (csel[fct_pkg::COMP_W-1])
                            n_next[dsel_reg] = (q > NUM_W'(8192)) ? NW'(-8192) : NW'(-q);
                        else
                            n_next[dsel_reg] = (q > NUM_W'(8191)) ? NW'(8191) : NW'(q);
                        dsel_next = dsel_reg + 1'b1;
                        drem_next = '0;
                        quo_next  = div_num(comp_reg[dsel_reg + 2'd1], dsel_reg == 2'd2,
                                            root_reg);
                    end
                end
            end
            fct_pkg::PG_STORE:
            begin
                wr.en = 1'b1;
                if (p_reg == PW'(NUM_PLANES - 1))
                begin
                    state_next = fct_pkg::PG_IDLE;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = fct_pkg::PG_LOAD;
                end
            end
            default:
            begin
                state_next = fct_pkg::PG_IDLE;
            end
        endcase

        // A register write restarts derivation from the first plane
        if (kick)
        begin
            p_next     = '0;
            state_next = fct_pkg::PG_LOAD;
        end
    end

    assign busy = state_reg != fct_pkg::PG_IDLE;

endmodule

`default_nettype wire
